### rtl/pclm_pkg.sv
// Shared types and codes for the priority ceiling lock manager.
// Depends on nothing; imported by priority_ceiling_lock_manager.
package pclm_pkg;

    localparam int THREAD_ID_W = 4;
    localparam int MUTEX_ID_W  = 4;
    localparam int PRIO_IN_W   = 8;
    localparam int STATUS_W    = 3;

    // The last op code has no function; such a word is taken and dropped.
    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_LOCK     = 2'd1,
        OP_UNLOCK   = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 3'd0,
        ST_NOT_REG    = 3'd1,
        ST_BLOCKED    = 3'd2,
        ST_BUSY       = 3'd3,
        ST_RELEASED   = 3'd4,
        ST_NOT_OWNER  = 3'd5,
        ST_REGISTERED = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_RESULT
    } state_t;

endpackage

### rtl/priority_ceiling_lock_manager.sv
// Priority ceiling lock manager: per-mutex table in one synchronous memory plus its sequencer.
// Depends on pclm_pkg for op, status and state codes.
//
//  Channel | Handshake           | Word fields
//  --------+---------------------+-----------------------------------------------------------
//  in      | in_valid / in_stall | op, thread_id, priority_req, mutex_id
//  out     | out_valid/out_stall | status, blocking_thread, blocking_mutex, blocking_ceiling
//
// Sequence: a register or unlock word goes from acceptance through fetch and evaluate to a
// loaded result (accept, fetch, evaluate, result). A lock word that passes the registration
// check also runs the scan, scan-end and decide states: the held-by-other scan reads one
// table entry per cycle through the single memory read port and one comparator.
// A word with the unused op code is accepted and dropped.
// Reset: rst_n clears the sequencer, the output valid and one valid flag per table entry;
// an entry whose flag is clear reads as free with zero ceiling and no users, so no clearing
// pass is needed and the block takes words right after reset.
// Stalls: in_stall is high whenever a word is in progress. A finished result sits in the
// output register while out_stall is high, and the next word is accepted meanwhile; that
// word waits in the result state only if its own result is ready before the old one leaves.
module priority_ceiling_lock_manager #(
    parameter int MUTEX_COUNT   = 16,
    parameter int THREAD_COUNT  = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           op,
    input  logic [pclm_pkg::THREAD_ID_W-1:0]     thread_id,
    input  logic [pclm_pkg::PRIO_IN_W-1:0]       priority_req,
    input  logic [pclm_pkg::MUTEX_ID_W-1:0]      mutex_id,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pclm_pkg::STATUS_W-1:0]        status,
    output logic [pclm_pkg::THREAD_ID_W-1:0]     blocking_thread,
    output logic [pclm_pkg::MUTEX_ID_W-1:0]      blocking_mutex,
    output logic [pclm_pkg::PRIO_IN_W-1:0]       blocking_ceiling
);
    import pclm_pkg::*;

    // Table address width and a scan counter that can also hold the entry count.
    localparam int MW    = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
    localparam int CW    = MW + 1;
    localparam int TW    = $clog2(THREAD_COUNT);
    localparam int PB    = PRIORITY_BITS;
    localparam int WIDEP = (PB > PRIO_IN_W) ? PB : PRIO_IN_W;

    localparam logic [8:0]    MUTEX_LIMIT  = 9'(MUTEX_COUNT);
    localparam logic [6:0]    THREAD_LIMIT = 7'(THREAD_COUNT);
    localparam logic [CW-1:0] SCAN_LAST    = CW'(MUTEX_COUNT - 1);

    // One table word per mutex.
    typedef struct packed {
        logic                   held;
        logic [THREAD_ID_W-1:0] holder;
        logic [PB-1:0]          ceiling;
        logic [THREAD_COUNT-1:0] users;
    } entry_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [1:0]             op_reg;
    logic [THREAD_ID_W-1:0] tid_reg;
    logic [PB-1:0]          prio_reg;
    logic [MUTEX_ID_W-1:0]  mid_reg;

    entry_t                 mem [MUTEX_COUNT];
    entry_t                 rd_data_reg;
    logic                   rd_vld_reg;
    logic [MUTEX_COUNT-1:0] vld_reg;

    entry_t                 ent_m_reg;
    logic [CW-1:0]          scan_reg;
    logic                   cmp_vld_reg;
    logic [MW-1:0]          cmp_idx_reg;
    logic                   found_reg;
    logic [MW-1:0]          best_idx_reg;
    logic [PB-1:0]          best_ceil_reg;
    logic [THREAD_ID_W-1:0] best_thread_reg;

    logic [STATUS_W-1:0]    res_status_reg;
    logic [THREAD_ID_W-1:0] res_thread_reg;
    logic [MUTEX_ID_W-1:0]  res_mutex_reg;
    logic [PRIO_IN_W-1:0]   res_ceil_reg;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [THREAD_ID_W-1:0] bthread_reg;
    logic [MUTEX_ID_W-1:0]  bmutex_reg;
    logic [PRIO_IN_W-1:0]   bceil_reg;

    // ------------------------------------------------------------------
    // Decoded request and the entry as read
    // ------------------------------------------------------------------
    logic          in_accept;
    logic          m_ok;
    logic          t_ok;
    logic [MW-1:0] m_idx;
    logic [TW-1:0] t_idx;
    entry_t        ent_rd;
    logic          out_free;
    logic          blocked;

    assign in_accept = in_valid && !in_stall;
    assign m_ok      = 9'(mid_reg) < MUTEX_LIMIT;
    assign t_ok      = 7'(tid_reg) < THREAD_LIMIT;
    assign m_idx     = MW'(mid_reg);
    assign t_idx     = TW'(tid_reg);
    // A table word never written since reset reads as a free, unused mutex.
    assign ent_rd    = rd_vld_reg ? rd_data_reg : '0;
    assign out_free  = !out_valid_reg || !out_stall;
    assign blocked   = found_reg && (prio_reg <= best_ceil_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // The unused op code is taken and dropped without a result.
                if (in_accept && (op != OP_UNUSED))
                    state_next = S_FETCH;
            end
            S_FETCH:
                state_next = S_EVAL;
            S_EVAL:
            begin
                if ((op_reg == OP_LOCK) && m_ok && t_ok && ent_rd.users[t_idx])
                    state_next = S_SCAN;
                else
                    state_next = S_RESULT;
            end
            S_SCAN:
            begin
                if (scan_reg == SCAN_LAST)
                    state_next = S_SCAN_END;
            end
            S_SCAN_END:
                state_next = S_DECIDE;
            S_DECIDE:
                state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: memory port controls and result staging
    // ------------------------------------------------------------------
    logic                   mem_rd_en;
    logic [MW-1:0]          mem_rd_addr;
    logic                   mem_wr_en;
    logic [MW-1:0]          mem_wr_addr;
    entry_t                 mem_wr_data;
    logic                   res_load;
    logic [STATUS_W-1:0]    res_status;
    logic                   res_blocked;
    logic                   scan_start;
    logic                   out_load;

    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = m_idx;
        mem_wr_data = ent_rd;
        res_load    = 1'b0;
        res_status  = ST_NOT_REG;
        res_blocked = 1'b0;
        scan_start  = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_FETCH:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = m_ok ? m_idx : '0;
            end
            S_EVAL:
            begin
                unique case (op_reg)
                    OP_REGISTER:
                    begin
                        res_load = 1'b1;
                        if (m_ok && t_ok)
                        begin
                            mem_wr_en                = 1'b1;
                            mem_wr_data.users[t_idx] = 1'b1;
                            if (prio_reg > ent_rd.ceiling)
                                mem_wr_data.ceiling = prio_reg;
                            res_status = ST_REGISTERED;
                        end
                    end
                    OP_LOCK:
                    begin
                        if (m_ok && t_ok && ent_rd.users[t_idx])
                            scan_start = 1'b1;
                        else
                            res_load = 1'b1;
                    end
                    OP_UNLOCK:
                    begin
                        res_load = 1'b1;
                        if (m_ok && ent_rd.held && (ent_rd.holder == tid_reg))
                        begin
                            mem_wr_en        = 1'b1;
                            mem_wr_data.held = 1'b0;
                            res_status       = ST_RELEASED;
                        end
                        else
                        begin
                            res_status = ST_NOT_OWNER;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = scan_reg[MW-1:0];
            end
            S_SCAN_END:
            begin
            end
            S_DECIDE:
            begin
                res_load = 1'b1;
                if (blocked)
                begin
                    res_status  = ST_BLOCKED;
                    res_blocked = 1'b1;
                end
                else if (ent_m_reg.held)
                begin
                    res_status = ST_BUSY;
                end
                else
                begin
                    mem_wr_en          = 1'b1;
                    mem_wr_data        = ent_m_reg;
                    mem_wr_data.held   = 1'b1;
                    mem_wr_data.holder = tid_reg;
                    res_status         = ST_GRANTED;
                end
            end
            S_RESULT:
                out_load = out_free;
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Table memory. Writes happen only in the evaluate and decide states, and
    // the result and idle states always lie between a write and the next read
    // of any entry, so no forwarding path is needed.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en)
            rd_data_reg <= mem[mem_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_wr_en)
                vld_reg[mem_wr_addr] <= 1'b1;
            if (mem_rd_en)
                rd_vld_reg <= vld_reg[mem_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == S_SCAN);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic [WIDEP-1:0] best_ceil_wide;

    assign best_ceil_wide = WIDEP'(best_ceil_reg);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= op;
            tid_reg  <= thread_id;
            prio_reg <= PB'(priority_req);
            mid_reg  <= mutex_id;
        end

        if (scan_start)
        begin
            ent_m_reg <= ent_rd;
            scan_reg  <= '0;
            found_reg <= 1'b0;
        end
        else if (state_reg == S_SCAN)
        begin
            scan_reg <= scan_reg + CW'(1);
        end

        if (state_reg == S_SCAN)
            cmp_idx_reg <= scan_reg[MW-1:0];

        // One comparator: keep the first entry with the highest ceiling among
        // mutexes held by some other thread.
        if (cmp_vld_reg && ent_rd.held && (ent_rd.holder != tid_reg)
            && (!found_reg || (ent_rd.ceiling > best_ceil_reg)))
        begin
            found_reg       <= 1'b1;
            best_idx_reg    <= cmp_idx_reg;
            best_ceil_reg   <= ent_rd.ceiling;
            best_thread_reg <= ent_rd.holder;
        end

        if (res_load)
        begin
            res_status_reg <= res_status;
            res_thread_reg <= res_blocked ? best_thread_reg : '0;
            res_mutex_reg  <= res_blocked ? MUTEX_ID_W'(best_idx_reg) : '0;
            res_ceil_reg   <= res_blocked ? best_ceil_wide[PRIO_IN_W-1:0] : '0;
        end

        if (out_load)
        begin
            status_reg  <= res_status_reg;
            bthread_reg <= res_thread_reg;
            bmutex_reg  <= res_mutex_reg;
            bceil_reg   <= res_ceil_reg;
        end
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign blocking_thread  = bthread_reg;
    assign blocking_mutex   = bmutex_reg;
    assign blocking_ceiling = bceil_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A new result never overwrites one that the receiver is still stalling.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register loaded while a stalled result is pending");

    // A word with a meaningful op code always starts a table fetch.
    a_fetch_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (op != OP_UNUSED)) |=> (state_reg == S_FETCH))
        else $error("accepted word did not start a fetch");

    // A grant is only written for a mutex that was free when it was read.
    a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && mem_wr_en) |-> (!ent_m_reg.held && !blocked))
        else $error("lock granted on a held or blocked mutex");

    // The scan ends with the comparator holding the last entry's data.
    a_scan_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_END) |-> cmp_vld_reg)
        else $error("scan finished without comparing the last entry");

endmodule

### tb/tb.sv
// Self-checking testbench for priority_ceiling_lock_manager: directed and random request words.
// Needs pclm_pkg and the lock manager RTL. The predictor lives in a small scoreboard class.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pclm_pkg::*;

    // The block is built with its default sizes, so every 4-bit index is in range.
    localparam int          MUTEXES     = 16;
    localparam int          THREADS     = 16;
    localparam int          RANDOM_WORDS = 950;
    localparam int          QUIET_LIMIT = 5000;
    localparam int          TAIL_CYCLES = 40;
    localparam int          IDLE_PCT    = 29;

    typedef struct packed {
        status_t     status;
        logic [3:0]  blk_thread;
        logic [3:0]  blk_mutex;
        logic [7:0]  blk_ceiling;
    } lock_answer_t;

    // The scoreboard keeps its own copy of the mutex table. Every accepted request word
    // other than the unused op code is run against that table and queues the answer the block must give back.
    class lock_ledger;
        bit           held    [MUTEXES];
        logic [3:0]   owner   [MUTEXES];
        logic [7:0]   ceiling [MUTEXES];
        logic [15:0]  users   [MUTEXES];
        lock_answer_t answers [$];
        int           mismatches;

        function new();
            for (int i = 0; i < MUTEXES; i++)
            begin
                held[i]    = 1'b0;
                owner[i]   = '0;
                ceiling[i] = '0;
                users[i]   = '0;
            end
            mismatches = 0;
        endfunction

        function void note_request(logic [1:0] op_v, logic [3:0] tid, logic [7:0] prio,
                                   logic [3:0] mid);
            lock_answer_t ans;
            bit           found;
            int           top;
            ans   = '0;
            found = 1'b0;
            top   = 0;
            case (op_v)
                OP_REGISTER:
                begin
                    users[mid][tid] = 1'b1;
                    if (prio > ceiling[mid])
                        ceiling[mid] = prio;
                    ans.status = ST_REGISTERED;
                end
                OP_LOCK:
                begin
                    if (!users[mid][tid])
                    begin
                        ans.status = ST_NOT_REG;
                    end
                    else
                    begin
                        // Highest ceiling among mutexes held by someone else; the
                        // strict compare keeps the lowest index on a tie.
                        for (int i = 0; i < MUTEXES; i++)
                        begin
                            if (held[i] && owner[i] != tid &&
                                (!found || ceiling[i] > ceiling[top]))
                            begin
                                found = 1'b1;
                                top   = i;
                            end
                        end
                        if (found && prio <= ceiling[top])
                        begin
                            ans.status      = ST_BLOCKED;
                            ans.blk_thread  = owner[top];
                            ans.blk_mutex   = 4'(top);
                            ans.blk_ceiling = ceiling[top];
                        end
                        else if (held[mid])
                        begin
                            ans.status = ST_BUSY;
                        end
                        else
                        begin
                            held[mid]  = 1'b1;
                            owner[mid] = tid;
                            ans.status = ST_GRANTED;
                        end
                    end
                end
                OP_UNLOCK:
                begin
                    if (held[mid] && owner[mid] == tid)
                    begin
                        held[mid]  = 1'b0;
                        ans.status = ST_RELEASED;
                    end
                    else
                    begin
                        ans.status = ST_NOT_OWNER;
                    end
                end
                default:
                    return;
            endcase
            answers = {answers, ans};
        endfunction

        function void check_result(logic [2:0] st, logic [3:0] bt, logic [3:0] bm,
                                   logic [7:0] bc);
            lock_answer_t ans;
            if (answers.size() == 0)
            begin
                $error("result word with no answer pending: status %0d", st);
                mismatches++;
                return;
            end
            ans = answers.pop_front();
            if (st !== ans.status)
            begin
                $error("status: expected %0d, got %0d", ans.status, st);
                mismatches++;
            end
            if (bt !== ans.blk_thread)
            begin
                $error("blocking_thread: expected %0d, got %0d", ans.blk_thread, bt);
                mismatches++;
            end
            if (bm !== ans.blk_mutex)
            begin
                $error("blocking_mutex: expected %0d, got %0d", ans.blk_mutex, bm);
                mismatches++;
            end
            if (bc !== ans.blk_ceiling)
            begin
                $error("blocking_ceiling: expected %0d, got %0d", ans.blk_ceiling, bc);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic [3:0]  thread_id = '0;
    logic [7:0]  priority_req = '0;
    logic [3:0]  mutex_id = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [3:0]  blocking_thread;
    logic [3:0]  blocking_mutex;
    logic [7:0]  blocking_ceiling;

    // While calm is set neither side inserts idle cycles, so the block runs back to back.
    bit          calm = 1'b0;
    lock_ledger  ledger = new();

    priority_ceiling_lock_manager DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .thread_id        (thread_id),
        .priority_req     (priority_req),
        .mutex_id         (mutex_id),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .blocking_thread  (blocking_thread),
        .blocking_mutex   (blocking_mutex),
        .blocking_ceiling (blocking_ceiling)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Every task below is resumed right after a rising edge, so a read of a block
    // output sees the value that was present at that edge, and every drive is an
    // NBA that the block sees at the following edge.

    // Offers one request word, with a random number of idle cycles in front of it,
    // and returns in the time step of the edge that accepted it.
    task automatic send_word(logic [1:0] op_v, logic [3:0] tid, logic [7:0] prio,
                             logic [3:0] mid);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= op_v;
        thread_id    <= tid;
        priority_req <= prio;
        mutex_id     <= mid;
        do
            @(posedge clk);
        while (in_stall);
        ledger.note_request(op_v, tid, prio, mid);
    endtask

    // Holds the request side quiet until the block has answered everything.
    task automatic drain_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.answers.size() != 0)
            @(posedge clk);
    endtask

    // Each thread has a fixed base priority spread over the full 8-bit range, so
    // a mutex ceiling is usually the base of its strongest user and equal ceilings on
    // different mutexes come up naturally.
    function automatic logic [7:0] base_priority(logic [3:0] tid);
        return 8'(tid) * 8'd17;
    endfunction

    // One random request word. Most words form sensible traffic: locks come from
    // threads registered with the mutex, unlocks mostly from the real owner.
    // The rest are stray requests and the unused op code.
    task automatic random_word();
        logic [1:0]  op_v;
        logic [3:0]  tid;
        logic [3:0]  mid;
        logic [7:0]  prio;
        int          pick;
        int          start;
        int          held_ids [$];
        bit          chosen;
        pick = $urandom_range(0, 99);
        tid  = 4'($urandom);
        mid  = 4'($urandom);
        prio = 8'($urandom);
        chosen = 1'b0;
        if (pick < 22)
        begin
            op_v = OP_REGISTER;
            if ($urandom_range(0, 9) < 8)
                prio = base_priority(tid);
        end
        else if (pick < 65)
        begin
            op_v = OP_LOCK;
            if (ledger.users[mid] != 0 && $urandom_range(0, 9) < 8)
            begin
                start = $urandom_range(0, THREADS - 1);
                for (int k = 0; k < THREADS; k++)
                begin
                    if (!chosen && ledger.users[mid][(start + k) % THREADS])
                    begin
                        tid    = 4'((start + k) % THREADS);
                        chosen = 1'b1;
                    end
                end
            end
            // Priorities equal to some ceiling exercise the "not strictly above" edge.
            case ($urandom_range(0, 4))
                0, 1, 2: prio = base_priority(tid);
                3:       prio = ledger.ceiling[$urandom_range(0, MUTEXES - 1)];
                default: prio = 8'($urandom);
            endcase
        end
        else if (pick < 93)
        begin
            op_v = OP_UNLOCK;
            for (int i = 0; i < MUTEXES; i++)
                if (ledger.held[i])
                    held_ids = {held_ids, i};
            if (held_ids.size() != 0 && $urandom_range(0, 9) < 7)
            begin
                mid = 4'(held_ids[$urandom_range(0, held_ids.size() - 1)]);
                tid = ledger.owner[mid];
            end
        end
        else
        begin
            op_v = OP_UNUSED;
        end
        send_word(op_v, tid, prio, mid);
    endtask

    // Result side: checks every accepted result word and stalls at random.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                ledger.check_result(status, blocking_thread, blocking_mutex, blocking_ceiling);
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: a run that stops moving words in either direction is a failure.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening. Lock before any registration must be refused.
        send_word(OP_LOCK,     4'd0,  8'd0,   4'd0);
        send_word(OP_REGISTER, 4'd0,  8'd0,   4'd0);
        send_word(OP_REGISTER, 4'd15, 8'd255, 4'd15);
        send_word(OP_REGISTER, 4'd15, 8'd128, 4'd0);
        // Grant on an empty table, then busy when the holder asks again.
        send_word(OP_LOCK,     4'd0,  8'd0,   4'd0);
        send_word(OP_LOCK,     4'd0,  8'd0,   4'd0);
        // Thread 15 is above the ceiling held by thread 0 and gets its own mutex.
        send_word(OP_LOCK,     4'd15, 8'd255, 4'd15);
        // A priority equal to the other holder's ceiling is blocked.
        send_word(OP_LOCK,     4'd15, 8'd128, 4'd0);
        send_word(OP_REGISTER, 4'd5,  8'hAA,  4'd3);
        send_word(OP_REGISTER, 4'd10, 8'h55,  4'd12);
        // Lock by an unregistered thread, unlock by a non-owner, unlock of a free mutex.
        send_word(OP_LOCK,     4'd0,  8'd0,   4'd15);
        send_word(OP_UNLOCK,   4'd0,  8'd0,   4'd15);
        send_word(OP_UNLOCK,   4'd3,  8'd0,   4'd7);
        // Blocked by the highest ceiling of two held mutexes, then granted once it goes.
        send_word(OP_LOCK,     4'd5,  8'hAA,  4'd3);
        send_word(OP_UNLOCK,   4'd15, 8'd255, 4'd15);
        send_word(OP_LOCK,     4'd5,  8'hAA,  4'd3);
        send_word(OP_LOCK,     4'd10, 8'h55,  4'd12);
        // The unused op code is swallowed without an answer.
        send_word(OP_UNUSED,   4'd15, 8'd255, 4'd15);
        send_word(OP_UNLOCK,   4'd0,  8'd0,   4'd0);
        send_word(OP_UNLOCK,   4'd5,  8'hAA,  4'd3);
        // Two held mutexes with the same ceiling: the lower index is reported.
        send_word(OP_REGISTER, 4'd1,  8'd200, 4'd1);
        send_word(OP_REGISTER, 4'd1,  8'd200, 4'd2);
        send_word(OP_LOCK,     4'd1,  8'd200, 4'd2);
        send_word(OP_LOCK,     4'd1,  8'd200, 4'd1);
        send_word(OP_LOCK,     4'd15, 8'd200, 4'd0);
        drain_answers();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // A stretch in the middle runs with no idle cycles on either side.
            calm = (n >= 350 && n < 550);
            random_word();
            if (n == 700)
                drain_answers();
        end
        calm = 1'b0;

        drain_answers();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.answers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
